[sv/cprg_pkg.sv]
// Shared types and constants for the camera primary ray generator.
// No dependencies; every other file refers to it by scoped names.
package cprg_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIR_FRAC  = 14;
    localparam int QW        = DIR_FRAC + 1;
    localparam int SQRT_STEPS = 32;
    // sum of the front, square root, divider and output register delays
    localparam int LATENCY   = 9 + SQRT_STEPS + 1 + QW + 1 + 1;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FOCAL  = 3'd2;
    localparam logic [2:0] REG_RIGHT  = 3'd3;
    localparam logic [2:0] REG_UP     = 3'd4;
    localparam logic [2:0] REG_VIEW   = 3'd5;

    localparam logic [12:0] RST_WIDTH  = 13'd600;
    localparam logic [12:0] RST_HEIGHT = 13'd400;
    localparam logic [23:0] RST_FOCAL  = 24'd48432;
    localparam logic [47:0] RST_RIGHT  = 48'h4000_0000_0000;
    localparam logic [47:0] RST_UP     = 48'h0000_4000_0000;
    localparam logic [47:0] RST_VIEW   = 48'h0000_0000_C000;

    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [23:0] inv_focal;
        logic [47:0] right;
        logic [47:0] up;
        logic [47:0] view;
    } cprg_cfg_t;

    typedef struct packed {
        logic [11:0]       row;
        logic [11:0]       col;
        logic              zero;
        logic [2:0]        neg;
        logic [2:0][30:0]  mg;
    } cprg_side_t;

endpackage

[sv/cprg_front.sv]
// Direction forming, basis rotation, magnitude normalization and sum of squares.
// Depends on cprg_pkg.
module cprg_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [11:0]            row,
    input  logic [11:0]            col,
    input  cprg_pkg::cprg_cfg_t    cfg,
    output logic                   out_valid,
    output logic [63:0]            sum,
    output cprg_pkg::cprg_side_t   side
);

    logic [8:0] valid_reg;
    logic [11:0] row_reg [0:8];
    logic [11:0] col_reg [0:8];

    logic signed [14:0] hx_reg, hy_reg;
    logic signed [39:0] ax_reg, ay_reg;
    logic signed [55:0] pr_reg [0:2];
    logic signed [55:0] pu_reg [0:2];
    logic signed [57:0] pv_reg [0:2];
    logic [56:0] mag4_reg [0:2];
    logic [56:0] mag5_reg [0:2];
    logic [56:0] mag6_reg [0:2];
    logic [56:0] mx_reg;
    logic [5:0]  len_reg;
    logic [2:0]  neg_reg [4:9];
    logic        zero_reg [6:9];
    logic [30:0] mg7_reg [0:2];
    logic [30:0] mg8_reg [0:2];
    logic [30:0] mg9_reg [0:2];
    logic [61:0] sq_reg [0:2];
    logic [63:0] sum_reg;

    logic [12:0] cw, ch;
    logic signed [14:0] hx_next, hy_next;
    logic signed [57:0] w_next [0:2];
    logic [56:0] mx_next;
    logic [5:0]  len_next;
    logic [30:0] mg_next [0:2];
    logic [5:0]  sh_r, sh_l;

    always_comb
    begin
        cw = (cfg.width > 13'(cprg_pkg::MAX_DIM)) ? 13'(cprg_pkg::MAX_DIM) : cfg.width;
        ch = (cfg.height > 13'(cprg_pkg::MAX_DIM)) ? 13'(cprg_pkg::MAX_DIM) : cfg.height;
        hx_next = $signed({2'b00, col, 1'b0}) - $signed({2'b00, cw}) + 15'sd1;
        hy_next = $signed({2'b00, row, 1'b0}) - $signed({2'b00, ch}) + 15'sd1;
        for (int i = 0; i < 3; i++)
        begin
            w_next[i] = {{2{pr_reg[i][55]}}, pr_reg[i]} + {{2{pu_reg[i][55]}}, pu_reg[i]}
                      + pv_reg[i];
        end
        mx_next = mag4_reg[0];
        if (mag4_reg[1] > mx_next)
        begin
            mx_next = mag4_reg[1];
        end
        if (mag4_reg[2] > mx_next)
        begin
            mx_next = mag4_reg[2];
        end
        len_next = '0;
        for (int j = 0; j < 57; j++)
        begin
            if (mx_reg[j])
            begin
                len_next = 6'(j + 1);
            end
        end
        sh_r = len_reg - 6'd31;
        sh_l = 6'd31 - len_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (len_reg > 6'd31)
            begin
                mg_next[i] = 31'(mag6_reg[i] >> sh_r);
            end
            else
            begin
                mg_next[i] = 31'(mag6_reg[i] << sh_l);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[7:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg[0] <= row;
        col_reg[0] <= col;
        for (int s = 1; s < 9; s++)
        begin
            row_reg[s] <= row_reg[s-1];
            col_reg[s] <= col_reg[s-1];
        end
        // stage 1: pixel offsets from the image center, doubled
        hx_reg <= hx_next;
        hy_reg <= hy_next;
        // stage 2: scale by the focal factor
        ax_reg <= hx_reg * $signed({1'b0, cfg.inv_focal});
        ay_reg <= hy_reg * $signed({1'b0, cfg.inv_focal});
        // stage 3: rotate into world space
        for (int i = 0; i < 3; i++)
        begin
            pr_reg[i] <= ax_reg * $signed(cfg.right[47-16*i -: 16]);
            pu_reg[i] <= ay_reg * $signed(cfg.up[47-16*i -: 16]);
            pv_reg[i] <= {{17{cfg.view[47-16*i]}}, cfg.view[47-16*i -: 16], 25'b0};
        end
        // stage 4: sum, sign and magnitude
        for (int i = 0; i < 3; i++)
        begin
            neg_reg[4][i] <= w_next[i][57];
            mag4_reg[i] <= w_next[i][57] ? 57'(-w_next[i]) : 57'(w_next[i]);
        end
        // stage 5: largest magnitude
        mx_reg <= mx_next;
        neg_reg[5] <= neg_reg[4];
        for (int i = 0; i < 3; i++)
        begin
            mag5_reg[i] <= mag4_reg[i];
            mag6_reg[i] <= mag5_reg[i];
            mg8_reg[i] <= mg7_reg[i];
            mg9_reg[i] <= mg8_reg[i];
        end
        // stage 6: bit length of the largest
        len_reg <= len_next;
        zero_reg[6] <= (len_next == '0);
        neg_reg[6] <= neg_reg[5];
        // stage 7: align so the largest has 31 bits
        for (int i = 0; i < 3; i++)
        begin
            mg7_reg[i] <= mg_next[i];
        end
        zero_reg[7] <= zero_reg[6];
        neg_reg[7] <= neg_reg[6];
        // stage 8: squares
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= 62'(mg7_reg[i]) * 62'(mg7_reg[i]);
        end
        zero_reg[8] <= zero_reg[7];
        neg_reg[8] <= neg_reg[7];
        // stage 9: sum of squares
        sum_reg <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
        zero_reg[9] <= zero_reg[8];
        neg_reg[9] <= neg_reg[8];
    end

    assign out_valid = valid_reg[8];
    assign sum = sum_reg;
    assign side.row = row_reg[8];
    assign side.col = col_reg[8];
    assign side.zero = zero_reg[9];
    assign side.neg = neg_reg[9];
    assign side.mg[0] = mg9_reg[0];
    assign side.mg[1] = mg9_reg[1];
    assign side.mg[2] = mg9_reg[2];

endmodule

[sv/cprg_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on cprg_pkg.
module cprg_isqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [63:0]            x,
    input  cprg_pkg::cprg_side_t   side_in,
    output logic                   out_valid,
    output logic [31:0]            root,
    output cprg_pkg::cprg_side_t   side_out
);

    localparam int N = cprg_pkg::SQRT_STEPS;

    logic [N:0]           valid_reg;
    logic [63:0]          x_reg    [0:N];
    logic [63:0]          res_reg  [0:N];
    cprg_pkg::cprg_side_t side_reg [0:N];
    logic [63:0]          x_next   [1:N];
    logic [63:0]          res_next [1:N];

    always_comb
    begin
        logic [63:0] trial;
        logic [63:0] bitv;
        for (int k = 0; k < N; k++)
        begin
            bitv = 64'd1 << (62 - 2*k);
            trial = res_reg[k] + bitv;
            if (x_reg[k] >= trial)
            begin
                x_next[k+1] = x_reg[k] - trial;
                res_next[k+1] = (res_reg[k] >> 1) + bitv;
            end
            else
            begin
                x_next[k+1] = x_reg[k];
                res_next[k+1] = res_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= x;
        res_reg[0] <= '0;
        side_reg[0] <= side_in;
        for (int k = 1; k <= N; k++)
        begin
            x_reg[k] <= x_next[k];
            res_reg[k] <= res_next[k];
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = valid_reg[N];
    assign root = res_reg[N][31:0];
    assign side_out = side_reg[N];

endmodule

[sv/cprg_div.sv]
// Three-lane pipelined restoring divider, rounded unit components.
// Depends on cprg_pkg.
module cprg_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [31:0]            n,
    input  cprg_pkg::cprg_side_t   side_in,
    output logic                   out_valid,
    output logic [2:0][cprg_pkg::QW-1:0] quot,
    output cprg_pkg::cprg_side_t   side_out
);

    localparam int Q = cprg_pkg::QW;
    localparam int RW = 31 + cprg_pkg::DIR_FRAC + 1;
    localparam int DW = 32 + Q;

    logic [Q:0]           valid_reg;
    logic [31:0]          n_reg    [0:Q];
    cprg_pkg::cprg_side_t side_reg [0:Q];
    logic [RW-1:0]        rem_reg  [0:Q][0:2];
    logic [Q-1:0]         q_reg    [0:Q][0:2];
    logic [RW-1:0]        rem_next [1:Q][0:2];
    logic [Q-1:0]         q_next   [1:Q][0:2];

    always_comb
    begin
        logic [DW-1:0] dvs;
        for (int s = 0; s < Q; s++)
        begin
            dvs = DW'(n_reg[s]) << (Q - 1 - s);
            for (int i = 0; i < 3; i++)
            begin
                if (DW'(rem_reg[s][i]) >= dvs)
                begin
                    rem_next[s+1][i] = RW'(DW'(rem_reg[s][i]) - dvs);
                    q_next[s+1][i] = q_reg[s][i] | (Q'(1) << (Q - 1 - s));
                end
                else
                begin
                    rem_next[s+1][i] = rem_reg[s][i];
                    q_next[s+1][i] = q_reg[s][i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[Q-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg[0] <= n;
        side_reg[0] <= side_in;
        for (int i = 0; i < 3; i++)
        begin
            // numerator with half the divisor added for rounding
            rem_reg[0][i] <= {side_in.mg[i], cprg_pkg::DIR_FRAC'(0)} + RW'(n >> 1);
            q_reg[0][i] <= '0;
        end
        for (int s = 1; s <= Q; s++)
        begin
            n_reg[s] <= n_reg[s-1];
            side_reg[s] <= side_reg[s-1];
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[s][i] <= rem_next[s][i];
                q_reg[s][i] <= q_next[s][i];
            end
        end
    end

    assign out_valid = valid_reg[Q];
    assign side_out = side_reg[Q];
    assign quot[0] = q_reg[Q][0];
    assign quot[1] = q_reg[Q][1];
    assign quot[2] = q_reg[Q][2];

endmodule

[sv/camera_primary_ray_generator.sv]
// Pinhole camera primary ray generator: pixel in, unit world direction out.
// Each start yields a done after the front, square root, divider and output registers.
// Throughput: one pixel per cycle; busy stays low, the pipeline never stalls.
// The 32-stage square root and the 15-stage divider set the depth.
// Reset clears all valid bits and loads the default camera registers.
module camera_primary_ray_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] pixel_row,
    input  logic [11:0] pixel_col,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output logic        done,
    output logic [11:0] row_tag,
    output logic [11:0] col_tag,
    output logic signed [15:0] dir_x,
    output logic signed [15:0] dir_y,
    output logic signed [15:0] dir_z
);

    localparam int Q = cprg_pkg::QW;

    cprg_pkg::cprg_cfg_t  cfg_reg;
    cprg_pkg::cprg_side_t f_side, s_side, d_side;
    logic                 f_valid, s_valid, d_valid;
    logic [63:0]          f_sum;
    logic [31:0]          s_root;
    logic [2:0][Q-1:0]    d_quot;
    logic                 done_reg;
    logic [11:0]          row_reg, col_reg;
    logic [15:0]          dir_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width <= cprg_pkg::RST_WIDTH;
            cfg_reg.height <= cprg_pkg::RST_HEIGHT;
            cfg_reg.inv_focal <= cprg_pkg::RST_FOCAL;
            cfg_reg.right <= cprg_pkg::RST_RIGHT;
            cfg_reg.up <= cprg_pkg::RST_UP;
            cfg_reg.view <= cprg_pkg::RST_VIEW;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cprg_pkg::REG_WIDTH:  cfg_reg.width <= cfg_data[12:0];
                cprg_pkg::REG_HEIGHT: cfg_reg.height <= cfg_data[12:0];
                cprg_pkg::REG_FOCAL:  cfg_reg.inv_focal <= cfg_data[23:0];
                cprg_pkg::REG_RIGHT:  cfg_reg.right <= cfg_data;
                cprg_pkg::REG_UP:     cfg_reg.up <= cfg_data;
                cprg_pkg::REG_VIEW:   cfg_reg.view <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    cprg_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
        .row(pixel_row), .col(pixel_col), .cfg(cfg_reg),
        .out_valid(f_valid), .sum(f_sum), .side(f_side)
    );

    cprg_isqrt u_isqrt (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .x(f_sum), .side_in(f_side),
        .out_valid(s_valid), .root(s_root), .side_out(s_side)
    );

    cprg_div u_div (
        .clk(clk), .rst_n(rst_n), .in_valid(s_valid), .n(s_root), .side_in(s_side),
        .out_valid(d_valid), .quot(d_quot), .side_out(d_side)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= d_side.row;
        col_reg <= d_side.col;
        for (int i = 0; i < 3; i++)
        begin
            // drop to zero for a zero direction, else apply the sign
            if (d_side.zero)
            begin
                dir_reg[i] <= '0;
            end
            else if (d_side.neg[i])
            begin
                dir_reg[i] <= 16'(-(17'(d_quot[i])));
            end
            else
            begin
                dir_reg[i] <= 16'(d_quot[i]);
            end
        end
    end

    assign done = done_reg;
    assign row_tag = row_reg;
    assign col_tag = col_reg;
    assign dir_x = dir_reg[0];
    assign dir_y = dir_reg[1];
    assign dir_z = dir_reg[2];

endmodule

[sv/cprg_checker.sv]
// Port-level checks for the ray generator, bound to the top level.
// Depends on cprg_pkg and camera_primary_ray_generator.
module cprg_props (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [11:0] pixel_row,
    input logic [11:0] pixel_col,
    input logic        done,
    input logic [11:0] row_tag,
    input logic [11:0] col_tag,
    input logic signed [15:0] dir_x
);

    localparam int LAT = cprg_pkg::LATENCY;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a transaction");

    a_tags_echo: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (row_tag == $past(pixel_row, LAT)) && (col_tag == $past(pixel_col, LAT)))
        else $error("pixel tags out of order");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (dir_x <= 16'sd16384) && (dir_x >= -16'sd16384))
        else $error("direction component out of range");

endmodule

bind camera_primary_ray_generator cprg_props u_cprg_props (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .pixel_row(pixel_row), .pixel_col(pixel_col), .done(done),
    .row_tag(row_tag), .col_tag(col_tag), .dir_x(dir_x)
);
